>>> hw/rtl/tcre_pkg.sv
package tcre_pkg;

    // Default sizes
    localparam int MAX_POINTS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    // Fixed field widths
    localparam int COORD_W = 15;
    localparam int TIN_W   = 32;
    localparam int SEG_W   = 4;
    localparam int OUT_W   = 18;
    localparam int STAT_W  = 3;
    localparam int HELD_W  = 5;

    // Shared unit widths (sized for timestamps of up to 32 bits)
    localparam int UA_W  = 63;   // multiplicand or divisor magnitude
    localparam int UB_W  = 64;   // multiplier or dividend, MSB first
    localparam int UP_W  = 81;   // product or remainder
    localparam int UQ_W  = 58;   // quotient
    localparam int UC_W  = 6;    // step counter
    localparam int ACC_W = 64;   // signed Q8 accumulator
    localparam int PR_W  = 48;   // signed delta times interval
    localparam int S_W   = 50;   // magnitude of s in Q16

    // Step counts of the shared unit
    localparam logic [UC_W-1:0] MUL_SHORT = 6'd16;
    localparam logic [UC_W-1:0] MUL_LONG  = 6'd50;
    localparam logic [UC_W-1:0] DIV_LEN   = 6'd58;

    localparam logic signed [ACC_W-1:0] ACC_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    // Operation codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_EVAL   = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_EVAL     = 3'd0;
    localparam logic [STAT_W-1:0] ST_APPEND   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_SEG  = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERO_INT = 3'd4;

endpackage

>>> hw/rtl/tcre_ram.sv
module tcre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/timed_catmull_rom_evaluator.sv
// Append, full table and bad segment go from the input transfer straight to S_DONE;
// zero interval goes there after the fetch and S_CHECK. Evaluate: fetch of four points,
// one 58-step division for s, then per axis up to two tangents (16 + 16 + 58 steps each)
// and three 50-step Horner multiplies on one shift-add/subtract unit.
// One item at a time; the next transfer in the cycle after the result is registered.
// rst_n is asynchronous, active low: clears the point count and all control state.
module timed_catmull_rom_evaluator #(
    parameter int MAX_POINTS = tcre_pkg::MAX_POINTS_DEF,
    parameter int TIME_BITS  = tcre_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [tcre_pkg::COORD_W-1:0]        point_x,
    input  logic [tcre_pkg::COORD_W-1:0]        point_y,
    input  logic [tcre_pkg::TIN_W-1:0]          time_ms,
    input  logic [tcre_pkg::SEG_W-1:0]          segment,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tcre_pkg::OUT_W-1:0]   curve_x,
    output logic signed [tcre_pkg::OUT_W-1:0]   curve_y,
    output logic [tcre_pkg::STAT_W-1:0]         status,
    output logic [tcre_pkg::HELD_W-1:0]         points_held
);

    import tcre_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int TW  = TIME_BITS;
    localparam int DW  = TIME_BITS + 1;
    localparam int RW  = 2 * COORD_W + TIME_BITS;
    localparam int SUM_W = PR_W + 1;
    localparam int NUM_W = SUM_W + 8;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_CHECK, S_SDIV, S_TAN, S_TAN_W1, S_TAN_W2, S_TAN_W3,
        S_COEF, S_HORN, S_HORN_W, S_DONE
    } state_t;

    typedef struct packed {
        logic            go;
        logic            div;
        logic [UA_W-1:0] a;
        logic [UB_W-1:0] b;
        logic [UC_W-1:0] cnt;
    } ucmd_t;

    state_t state_reg, state_next;

    logic [SEG_W-1:0]   seg_reg, seg_next;
    logic [TW-1:0]      tin_reg, tin_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [2:0]         k_reg, k_next;
    logic [COORD_W-1:0] px_reg [4];
    logic [COORD_W-1:0] px_next [4];
    logic [COORD_W-1:0] py_reg [4];
    logic [COORD_W-1:0] py_next [4];
    logic [TW-1:0]      pt_reg [4];
    logic [TW-1:0]      pt_next [4];
    logic               use_p_reg, use_p_next, use_n_reg, use_n_next;
    logic signed [DW-1:0] h_reg, h_next, hp_reg, hp_next, hn_reg, hn_next;
    logic [S_W-1:0]     s_mag_reg, s_mag_next;
    logic               s_neg_reg, s_neg_next;
    logic               axis_reg, axis_next, tan_sel_reg, tan_sel_next;
    logic               t_neg_reg, t_neg_next;
    logic signed [PR_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0] m0_reg, m0_next, m1_reg, m1_next;
    logic signed [ACC_W-1:0] b_reg, b_next, acc_reg, acc_next;
    logic [1:0]         hs_reg, hs_next;
    logic signed [OUT_W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [STAT_W-1:0]  rstat_reg, rstat_next;
    logic [HELD_W-1:0]  rheld_reg, rheld_next;

    logic signed [OUT_W-1:0] curve_x_reg, curve_x_next, curve_y_reg, curve_y_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [HELD_W-1:0]  held_reg, held_next;
    logic               out_valid_reg, out_valid_next;

    // Shared unit
    ucmd_t              cmd;
    logic               u_div_reg, u_div_next;
    logic [UA_W-1:0]    u_a_reg, u_a_next;
    logic [UB_W-1:0]    u_b_reg, u_b_next;
    logic [UP_W-1:0]    u_p_reg, u_p_next;
    logic [UQ_W-1:0]    u_q_reg, u_q_next;
    logic [UC_W-1:0]    u_cnt_reg, u_cnt_next;
    logic               u_ovf_reg, u_ovf_next;
    logic               u_done;
    logic [UP_W-1:0]    u_shift, u_sum;

    // Table memory
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [RW-1:0]      ram_wdata, ram_rdata;

    // Working values
    logic [1:0]         kidx;
    logic [7:0]         seg_p1, seg_p2, count_ext;
    logic [COORD_W-1:0] pa [4];
    logic signed [DW-1:0] h_w, hp_w, hn_w, d_w, hf_w;
    logic [TW-1:0]      mag_h, mag_d, mag_hc, mag_hf;
    logic signed [COORD_W:0] dd_w, df_w;
    logic [COORD_W-1:0] mag_dd, mag_df;
    logic [TW+17:0]     s_num;
    logic signed [PR_W-1:0]  prod2_w;
    logic signed [SUM_W-1:0] sum_w;
    logic signed [NUM_W-1:0] num_w;
    logic [NUM_W-2:0]   mag_num;
    logic [UP_W-1:0]    p_round;
    logic [UP_W-17:0]   res_w;
    logic [UA_W-1:0]    res_mag, mag_acc;
    logic signed [ACC_W-1:0] prod_acc, addend, dd_acc, q_signed;
    logic signed [ACC_W:0]   hsum;
    logic signed [ACC_W-1:0] hsum_cl;
    logic [ACC_W-1:0]   rnd_w;
    logic [ACC_W-9:0]   rq_w;
    logic signed [OUT_W-1:0] fin_w;

    tcre_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared shift-add multiplier / restoring divider, one bit per cycle
    assign u_done  = (u_cnt_reg == '0);
    assign u_shift = {u_p_reg[UP_W-2:0], u_b_reg[UB_W-1] & u_div_reg};
    assign u_sum   = u_b_reg[UB_W-1] ? (u_shift + UP_W'(u_a_reg)) : u_shift;

    always_comb
    begin
        u_div_next = u_div_reg;
        u_a_next   = u_a_reg;
        u_b_next   = u_b_reg;
        u_p_next   = u_p_reg;
        u_q_next   = u_q_reg;
        u_cnt_next = u_cnt_reg;
        u_ovf_next = u_ovf_reg;
        if (cmd.go)
        begin
            u_div_next = cmd.div;
            u_a_next   = cmd.a;
            u_b_next   = cmd.b;
            u_p_next   = '0;
            u_q_next   = '0;
            u_cnt_next = cmd.cnt;
            u_ovf_next = 1'b0;
        end
        else if (!u_done)
        begin
            u_cnt_next = u_cnt_reg - UC_W'(1);
            u_b_next   = {u_b_reg[UB_W-2:0], 1'b0};
            if (u_div_reg)
            begin
                if (u_shift >= UP_W'(u_a_reg))
                begin
                    u_p_next = u_shift - UP_W'(u_a_reg);
                    u_q_next = {u_q_reg[UQ_W-2:0], 1'b1};
                end
                else
                begin
                    u_p_next = u_shift;
                    u_q_next = {u_q_reg[UQ_W-2:0], 1'b0};
                end
            end
            else if (!u_ovf_reg)
            begin
                // product only grows, so once past 2^79 it stays saturated
                u_p_next = u_sum;
                if (u_sum[UP_W-1:UP_W-2] != 2'b00)
                begin
                    u_ovf_next = 1'b1;
                end
            end
        end
    end

    // Interval and slope terms
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            pa[j] = axis_reg ? py_reg[j] : px_reg[j];
        end
        kidx      = k_reg[1:0] - 2'd1;
        seg_p1    = {4'b0, segment} + 8'd1;
        seg_p2    = {4'b0, segment} + 8'd2;
        count_ext = 8'(count_reg);

        h_w  = $signed({1'b0, pt_reg[2]}) - $signed({1'b0, pt_reg[1]});
        hp_w = use_p_reg ? ($signed({1'b0, pt_reg[1]}) - $signed({1'b0, pt_reg[0]}))
                         : DW'(1);
        hn_w = use_n_reg ? ($signed({1'b0, pt_reg[3]}) - $signed({1'b0, pt_reg[2]}))
                         : DW'(1);
        d_w  = $signed({1'b0, tin_reg}) - $signed({1'b0, pt_reg[1]});
        mag_h = h_w[DW-1] ? TW'(-h_w) : TW'(h_w);
        mag_d = d_w[DW-1] ? TW'(-d_w) : TW'(d_w);
        s_num = {mag_d, 17'b0} + (TW+18)'(mag_h);

        mag_hc = h_reg[DW-1] ? TW'(-h_reg) : TW'(h_reg);
        hf_w   = tan_sel_reg ? hn_reg : hp_reg;
        mag_hf = hf_w[DW-1] ? TW'(-hf_w) : TW'(hf_w);
        dd_w   = $signed({1'b0, pa[2]}) - $signed({1'b0, pa[1]});
        df_w   = tan_sel_reg ? ($signed({1'b0, pa[3]}) - $signed({1'b0, pa[2]}))
                             : ($signed({1'b0, pa[1]}) - $signed({1'b0, pa[0]}));
        mag_dd = dd_w[COORD_W] ? COORD_W'(-dd_w) : COORD_W'(dd_w);
        mag_df = df_w[COORD_W] ? COORD_W'(-df_w) : COORD_W'(df_w);

        prod2_w = (h_reg[DW-1] ^ df_w[COORD_W]) ? -$signed(PR_W'(u_p_reg))
                                               : $signed(PR_W'(u_p_reg));
        sum_w   = SUM_W'(prod_reg) + SUM_W'(prod2_w);
        num_w   = {sum_w, 8'b0};
        mag_num = num_w[NUM_W-1] ? (NUM_W-1)'(-num_w) : (NUM_W-1)'(num_w);
        q_signed = t_neg_reg ? -$signed(ACC_W'(u_q_reg)) : $signed(ACC_W'(u_q_reg));
        dd_acc  = ACC_W'(dd_w);

        // Horner step: round product to Q8, saturate, add next coefficient
        p_round = u_p_reg + UP_W'(17'h08000);
        res_w   = p_round[UP_W-1:16];
        res_mag = (u_ovf_reg || (res_w > (UP_W-16)'(ACC_LIM))) ? UA_W'(ACC_LIM)
                                                               : UA_W'(res_w);
        prod_acc = (acc_reg[ACC_W-1] ^ s_neg_reg) ? -$signed({1'b0, res_mag})
                                                  : $signed({1'b0, res_mag});
        case (hs_reg)
            2'd0:    addend = b_reg;
            2'd1:    addend = m0_reg;
            default: addend = $signed(ACC_W'({pa[1], 8'b0}));
        endcase
        hsum = (ACC_W+1)'(prod_acc) + (ACC_W+1)'(addend);
        if (hsum > (ACC_W+1)'(ACC_LIM))
        begin
            hsum_cl = ACC_LIM;
        end
        else if (hsum < -(ACC_W+1)'(ACC_LIM))
        begin
            hsum_cl = -ACC_LIM;
        end
        else
        begin
            hsum_cl = ACC_W'(hsum);
        end
        mag_acc = acc_reg[ACC_W-1] ? UA_W'(-acc_reg) : UA_W'(acc_reg);

        // Final rounding of the Q8 sum to an integer and saturation of the clamped sum
        rnd_w = ACC_W'(hsum_cl[ACC_W-1] ? UA_W'(-hsum_cl) : UA_W'(hsum_cl))
                + ACC_W'(128);
        rq_w  = rnd_w[ACC_W-1:8];
        if (hsum_cl[ACC_W-1])
        begin
            fin_w = (rq_w > (ACC_W-8)'(131072)) ? -18'sd131072 : -$signed(OUT_W'(rq_w));
        end
        else
        begin
            fin_w = (rq_w > (ACC_W-8)'(131071)) ? 18'sd131071 : $signed(OUT_W'(rq_w));
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        seg_next     = seg_reg;
        tin_next     = tin_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pt_next      = pt_reg;
        use_p_next   = use_p_reg;
        use_n_next   = use_n_reg;
        h_next       = h_reg;
        hp_next      = hp_reg;
        hn_next      = hn_reg;
        s_mag_next   = s_mag_reg;
        s_neg_next   = s_neg_reg;
        axis_next    = axis_reg;
        tan_sel_next = tan_sel_reg;
        t_neg_next   = t_neg_reg;
        prod_next    = prod_reg;
        m0_next      = m0_reg;
        m1_next      = m1_reg;
        b_next       = b_reg;
        acc_next     = acc_reg;
        hs_next      = hs_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        rstat_next   = rstat_reg;
        rheld_next   = rheld_reg;
        curve_x_next = curve_x_reg;
        curve_y_next = curve_y_reg;
        status_next  = status_reg;
        held_next    = held_reg;
        out_valid_next = out_valid_reg;
        cmd          = '0;
        ram_we       = 1'b0;
        ram_waddr    = AW'(count_reg);
        ram_wdata    = {point_x, point_y, time_ms[TW-1:0]};
        ram_raddr    = AW'(seg_reg) + AW'(k_reg) - AW'(1);
        in_ready     = (state_reg == S_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    seg_next   = segment;
                    tin_next   = time_ms[TW-1:0];
                    rx_next    = '0;
                    ry_next    = '0;
                    rheld_next = HELD_W'(count_reg);
                    state_next = S_DONE;
                    if (operation == OP_APPEND)
                    begin
                        if (count_reg < CW'(MAX_POINTS))
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            rheld_next = HELD_W'(count_reg + CW'(1));
                            rstat_next = ST_APPEND;
                        end
                        else
                        begin
                            rstat_next = ST_FULL;
                        end
                    end
                    else if (seg_p1 >= count_ext)
                    begin
                        rstat_next = ST_BAD_SEG;
                    end
                    else
                    begin
                        use_p_next = (segment != '0);
                        use_n_next = (seg_p2 < count_ext);
                        k_next     = '0;
                        state_next = S_FETCH;
                    end
                end
            end

            // points seg-1 .. seg+2, one read a cycle
            S_FETCH:
            begin
                if (k_reg != '0)
                begin
                    px_next[kidx] = ram_rdata[RW-1 -: COORD_W];
                    py_next[kidx] = ram_rdata[TW+COORD_W-1 -: COORD_W];
                    pt_next[kidx] = ram_rdata[TW-1:0];
                end
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd4)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                h_next  = h_w;
                hp_next = hp_w;
                hn_next = hn_w;
                if (h_w == '0 || hp_w == '0 || hn_w == '0)
                begin
                    rstat_next = ST_ZERO_INT;
                    state_next = S_DONE;
                end
                else
                begin
                    s_neg_next = d_w[DW-1] ^ h_w[DW-1];
                    cmd.go  = 1'b1;
                    cmd.div = 1'b1;
                    cmd.a   = UA_W'({mag_h, 1'b0});
                    cmd.b   = {UQ_W'(s_num), 6'b0};
                    cmd.cnt = DIV_LEN;
                    state_next = S_SDIV;
                end
            end

            S_SDIV:
            begin
                if (u_done)
                begin
                    s_mag_next   = S_W'(u_q_reg);
                    axis_next    = 1'b0;
                    tan_sel_next = 1'b0;
                    state_next   = S_TAN;
                end
            end

            // tangent: (dd*hf + df*h) * 256 / (2*hf)
            S_TAN:
            begin
                if (tan_sel_reg ? use_n_reg : use_p_reg)
                begin
                    cmd.go  = 1'b1;
                    cmd.a   = UA_W'(mag_hf);
                    cmd.b   = {1'b0, mag_dd, 48'b0};
                    cmd.cnt = MUL_SHORT;
                    state_next = S_TAN_W1;
                end
                else if (tan_sel_reg)
                begin
                    m1_next    = '0;
                    state_next = S_COEF;
                end
                else
                begin
                    m0_next      = '0;
                    tan_sel_next = 1'b1;
                end
            end

            S_TAN_W1:
            begin
                if (u_done)
                begin
                    prod_next = (hf_w[DW-1] ^ dd_w[COORD_W]) ? -$signed(PR_W'(u_p_reg))
                                                            : $signed(PR_W'(u_p_reg));
                    cmd.go  = 1'b1;
                    cmd.a   = UA_W'(mag_hc);
                    cmd.b   = {1'b0, mag_df, 48'b0};
                    cmd.cnt = MUL_SHORT;
                    state_next = S_TAN_W2;
                end
            end

            S_TAN_W2:
            begin
                if (u_done)
                begin
                    t_neg_next = num_w[NUM_W-1] ^ hf_w[DW-1];
                    cmd.go  = 1'b1;
                    cmd.div = 1'b1;
                    cmd.a   = UA_W'({mag_hf, 2'b0});
                    cmd.b   = {UQ_W'({mag_num, 1'b0}) + UQ_W'({mag_hf, 1'b0}), 6'b0};
                    cmd.cnt = DIV_LEN;
                    state_next = S_TAN_W3;
                end
            end

            S_TAN_W3:
            begin
                if (u_done)
                begin
                    if (tan_sel_reg)
                    begin
                        m1_next    = q_signed;
                        state_next = S_COEF;
                    end
                    else
                    begin
                        m0_next      = q_signed;
                        tan_sel_next = 1'b1;
                        state_next   = S_TAN;
                    end
                end
            end

            // A into the accumulator, B kept for the first Horner step
            S_COEF:
            begin
                acc_next = m0_reg + m1_reg - (dd_acc <<< 9);
                b_next   = (dd_acc <<< 9) + (dd_acc <<< 8) - (m0_reg <<< 1) - m1_reg;
                hs_next  = 2'd0;
                state_next = S_HORN;
            end

            S_HORN:
            begin
                cmd.go  = 1'b1;
                cmd.a   = mag_acc;
                cmd.b   = {s_mag_reg, 14'b0};
                cmd.cnt = MUL_LONG;
                state_next = S_HORN_W;
            end

            S_HORN_W:
            begin
                if (u_done)
                begin
                    acc_next = hsum_cl;
                    if (hs_reg == 2'd2)
                    begin
                        if (axis_reg)
                        begin
                            ry_next    = fin_w;
                            rstat_next = ST_EVAL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rx_next      = fin_w;
                            axis_next    = 1'b1;
                            tan_sel_next = 1'b0;
                            state_next   = S_TAN;
                        end
                    end
                    else
                    begin
                        hs_next    = hs_reg + 2'd1;
                        state_next = S_HORN;
                    end
                end
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    curve_x_next   = rx_reg;
                    curve_y_next   = ry_reg;
                    status_next    = rstat_reg;
                    held_next      = rheld_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            hs_reg        <= '0;
            axis_reg      <= 1'b0;
            tan_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            u_cnt_reg     <= '0;
            u_div_reg     <= 1'b0;
            u_ovf_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            hs_reg        <= hs_next;
            axis_reg      <= axis_next;
            tan_sel_reg   <= tan_sel_next;
            out_valid_reg <= out_valid_next;
            u_cnt_reg     <= u_cnt_next;
            u_div_reg     <= u_div_next;
            u_ovf_reg     <= u_ovf_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        seg_reg     <= seg_next;
        tin_reg     <= tin_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        pt_reg      <= pt_next;
        use_p_reg   <= use_p_next;
        use_n_reg   <= use_n_next;
        h_reg       <= h_next;
        hp_reg      <= hp_next;
        hn_reg      <= hn_next;
        s_mag_reg   <= s_mag_next;
        s_neg_reg   <= s_neg_next;
        t_neg_reg   <= t_neg_next;
        prod_reg    <= prod_next;
        m0_reg      <= m0_next;
        m1_reg      <= m1_next;
        b_reg       <= b_next;
        acc_reg     <= acc_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        rstat_reg   <= rstat_next;
        rheld_reg   <= rheld_next;
        curve_x_reg <= curve_x_next;
        curve_y_reg <= curve_y_next;
        status_reg  <= status_next;
        held_reg    <= held_next;
        u_a_reg     <= u_a_next;
        u_b_reg     <= u_b_next;
        u_p_reg     <= u_p_next;
        u_q_reg     <= u_q_next;
    end

    assign out_valid   = out_valid_reg;
    assign curve_x     = curve_x_reg;
    assign curve_y     = curve_y_reg;
    assign status      = status_reg;
    assign points_held = held_reg;

    // The shared unit only runs while the sequencer waits on it
    a_unit_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (u_cnt_reg != '0) |-> (state_reg == S_SDIV || state_reg == S_TAN_W1 ||
                               state_reg == S_TAN_W2 || state_reg == S_TAN_W3 ||
                               state_reg == S_HORN_W))
        else $error("shared unit busy outside a wait state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond table size");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation == OP_APPEND && count_reg < CW'(MAX_POINTS))
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted append did not grow the table");

    a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_EVAL) |-> (curve_x == '0 && curve_y == '0))
        else $error("curve value on a non-evaluated result");

endmodule
